// ===== sv/hxb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxb_pkg: shared types and constants for hex_text_to_bytes
// Scan modes, character codes and the request bundle that travels from the
// decoder to the result queue.
// ----------------------------------------------------------------------------
package hxb_pkg;

  localparam int MAX_DEC_DIGITS = 4;
  localparam int DEC_CNT_W      = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_SQUOTE = 8'h27;
  localparam logic [7:0] CHR_DQUOTE = 8'h22;
  localparam logic [7:0] CHR_LT     = 8'h3C;
  localparam logic [7:0] CHR_GT     = 8'h3E;
  localparam logic [7:0] CHR_LBRACE = 8'h7B;
  localparam logic [7:0] CHR_RBRACE = 8'h7D;
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_HASH   = 8'h23;

  typedef enum logic [1:0] {
    MODE_HEX = 2'd0,
    MODE_LIT = 2'd1,
    MODE_DEC = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] data0;
    logic [7:0] data1;
  } hxb_push_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hxb_entry_t;

endpackage

// ===== sv/hxb_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxb_decode: character decoder
// Holds the scan state and turns one registered character into zero, one or
// two output bytes per cycle.
// ----------------------------------------------------------------------------
module hxb_decode
  import hxb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      char_valid,
  input  logic [7:0] char_in,
  output hxb_push_t push
);

  scan_mode_t           mode_r, mode_nxt;
  logic [7:0]           close_r, close_nxt;
  logic [3:0]           hi_r, hi_nxt;
  logic                 pend_r, pend_nxt;
  logic [7:0]           val_r, val_nxt;
  logic [DEC_CNT_W-1:0] dig_r, dig_nxt;

  logic                 is_dec;
  logic                 is_hex;
  logic [3:0]           hex_val;
  logic [7:0]           dec_acc;
  logic [DEC_CNT_W-1:0] dig_inc;
  logic                 do_hex;

  always_comb begin
    is_dec  = (char_in >= 8'h30) && (char_in <= 8'h39);
    is_hex  = 1'b1;
    hex_val = char_in[3:0];
    if (is_dec) begin
      hex_val = char_in[3:0];
    end else if (((char_in >= 8'h61) && (char_in <= 8'h66)) ||
                 ((char_in >= 8'h41) && (char_in <= 8'h46))) begin
      hex_val = 4'(char_in[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
    dec_acc = 8'({val_r, 3'b000}) + 8'({val_r, 1'b0}) + {4'b0000, char_in[3:0]};
    dig_inc = dig_r + DEC_CNT_W'(1);
  end

  always_comb begin
    mode_nxt  = mode_r;
    close_nxt = close_r;
    hi_nxt    = hi_r;
    pend_nxt  = pend_r;
    val_nxt   = val_r;
    dig_nxt   = dig_r;
    push      = '0;
    do_hex    = 1'b0;

    if (char_valid) begin
      if (char_in == CHR_NUL) begin
        if (mode_r == MODE_DEC) begin
          push.cnt   = 2'd1;
          push.data0 = val_r;
        end
        mode_nxt  = MODE_HEX;
        close_nxt = '0;
        hi_nxt    = '0;
        pend_nxt  = 1'b0;
        val_nxt   = '0;
        dig_nxt   = '0;
      end else begin
        case (mode_r)
          MODE_LIT: begin
            if (char_in == close_r) begin
              mode_nxt = MODE_HEX;
            end else begin
              push.cnt   = 2'd1;
              push.data0 = char_in;
              if (pend_r) begin
                hi_nxt = '0;
              end
            end
          end
          MODE_DEC: begin
            if (is_dec) begin
              if (dig_inc >= DEC_CNT_W'(MAX_DEC_DIGITS)) begin
                push.cnt   = 2'd1;
                push.data0 = dec_acc;
                if (pend_r) begin
                  hi_nxt = '0;
                end
                val_nxt  = '0;
                dig_nxt  = '0;
                mode_nxt = MODE_HEX;
              end else begin
                val_nxt = dec_acc;
                dig_nxt = dig_inc;
              end
            end else begin
              push.cnt   = 2'd1;
              push.data0 = val_r;
              if (pend_r) begin
                hi_nxt = '0;
              end
              val_nxt  = '0;
              dig_nxt  = '0;
              mode_nxt = MODE_HEX;
              do_hex   = 1'b1;
            end
          end
          default: begin
            do_hex = 1'b1;
          end
        endcase
      end

      if (do_hex) begin
        if (is_hex) begin
          if (pend_nxt) begin
            if (push.cnt == 2'd0) begin
              push.data0 = {hi_nxt, hex_val};
            end else begin
              push.data1 = {hi_nxt, hex_val};
            end
            push.cnt = push.cnt + 2'd1;
            pend_nxt = 1'b0;
            hi_nxt   = '0;
          end else begin
            hi_nxt   = hex_val;
            pend_nxt = 1'b1;
          end
        end else begin
          case (char_in)
            CHR_SQUOTE: begin
              mode_nxt  = MODE_LIT;
              close_nxt = CHR_SQUOTE;
            end
            CHR_DQUOTE: begin
              mode_nxt  = MODE_LIT;
              close_nxt = CHR_DQUOTE;
            end
            CHR_LT: begin
              mode_nxt  = MODE_LIT;
              close_nxt = CHR_GT;
            end
            CHR_LBRACE: begin
              mode_nxt  = MODE_LIT;
              close_nxt = CHR_RBRACE;
            end
            CHR_LPAREN: begin
              mode_nxt  = MODE_LIT;
              close_nxt = CHR_RPAREN;
            end
            CHR_HASH: begin
              mode_nxt = MODE_DEC;
              val_nxt  = '0;
              dig_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HEX;
      close_r <= '0;
      hi_r    <= '0;
      pend_r  <= 1'b0;
      val_r   <= '0;
      dig_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      close_r <= close_nxt;
      hi_r    <= hi_nxt;
      pend_r  <= pend_nxt;
      val_r   <= val_nxt;
      dig_r   <= dig_nxt;
    end
  end

endmodule

// ===== sv/hxb_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxb_out_queue: result queue
// Takes up to two bytes per cycle from the decoder and hands one per cycle
// to the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module hxb_out_queue
  import hxb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hxb_push_t  push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output hxb_entry_t head
);

  hxb_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= '{data: push.data0, last: (push.cnt == 2'd1)};
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= '{data: push.data1, last: 1'b1};
    end
  end

endmodule

// ===== sv/hex_text_to_bytes.sv =====
`timescale 1ns / 1ps
// Order: a taken character waits in the input register until the result queue has room, then its bytes are queued.
// Throughput: one character per cycle while the result queue has room; a character that yields two bytes
// holds the single-byte result port for both of its bytes, and the four-entry result queue
// absorbs the difference.
// Reset: rst_n is synchronous and active low; it clears the scan state and empties the queue.
// ----------------------------------------------------------------------------
// hex_text_to_bytes: hex text to byte converter
// Input register, character decoder and result queue.
// ----------------------------------------------------------------------------
module hex_text_to_bytes
  import hxb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       room;
  logic       advance;
  hxb_push_t  push;
  hxb_entry_t head;

  assign advance  = s1_valid_r && room;
  assign in_ready = !s1_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char;
    end
  end

  hxb_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (advance),
    .char_in    (s1_char_r),
    .push       (push)
  );

  hxb_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte        = head.data;
  assign out_last_of_run = head.last;

endmodule

// ===== sv/hxb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hxb_checker: port checks for hex_text_to_bytes
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module hxb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A reset leaves the input side open.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // The second byte of a pair is queued together with the first.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("second byte of a pair missing");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled result changed");

endmodule

bind hex_text_to_bytes hxb_checker u_hxb_checker (.*);

// ===== dv/tb_hex_text_to_bytes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_text_to_bytes: self-checking testbench for the hex text decoder
// A short table of directed characters, some with typed-in results, is
// followed by random text built from hex pairs, literal runs, decimal runs,
// string ends and noise. Each accepted request is run through a local
// decoder model, and every result is checked in order against it, or against
// the typed-in result where a row gives one. Both handshakes idle in random
// bursts, except near the end of the run.
module tb_hex_text_to_bytes;
  import hxb_pkg::*;

  typedef struct packed {
    logic [7:0] chr;
    logic       typed;
    logic       has_byte;
    logic [7:0] value;
  } text_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  hex_text_to_bytes dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  localparam int DIR_ROWS   = 27;
  localparam int RAND_ITEMS = 1600;
  localparam int QUIET_TAIL = 200;

  text_row_t dir_tbl [0:DIR_ROWS-1] = '{
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{"f",   1'b1, 1'b0, 8'h00},
    '{"F",   1'b1, 1'b1, 8'hFF},
    '{"0",   1'b1, 1'b0, 8'h00},
    '{"0",   1'b1, 1'b1, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 8'h00},
    '{"{",   1'b1, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 8'hFF},
    '{8'h01, 1'b1, 1'b1, 8'h01},
    '{"}",   1'b1, 1'b0, 8'h00},
    '{"7",   1'b0, 1'b0, 8'h00},
    '{"#",   1'b0, 1'b0, 8'h00},
    '{"5",   1'b0, 1'b0, 8'h00},
    '{"b",   1'b0, 1'b0, 8'h00},
    '{"#",   1'b0, 1'b0, 8'h00},
    '{"9",   1'b0, 1'b0, 8'h00},
    '{"9",   1'b0, 1'b0, 8'h00},
    '{"9",   1'b0, 1'b0, 8'h00},
    '{"9",   1'b0, 1'b0, 8'h00},
    '{"7",   1'b0, 1'b0, 8'h00},
    '{"<",   1'b0, 1'b0, 8'h00},
    '{"x",   1'b0, 1'b0, 8'h00},
    '{">",   1'b0, 1'b0, 8'h00},
    '{"\"",  1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{"#",   1'b1, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, 8'h00}
  };

  text_row_t  text_q [$];
  out_byte_t  byte_q [$];
  logic [7:0] char_bytes [$];
  int         sent;
  int         errors;
  int         in_gap;
  int         out_gap;
  bit         quiet;
  bit         took;
  int         base;
  text_row_t  row;
  out_byte_t  want;

  scan_mode_t mdl_mode;
  logic [7:0] mdl_closer;
  logic [3:0] mdl_high;
  logic       mdl_pending;
  logic [7:0] mdl_dec_val;
  logic [2:0] mdl_dec_cnt;

  task automatic clear_scan();
    mdl_mode    = MODE_HEX;
    mdl_closer  = CHR_NUL;
    mdl_high    = 4'd0;
    mdl_pending = 1'b0;
    mdl_dec_val = 8'd0;
    mdl_dec_cnt = 3'd0;
  endtask

  task automatic emit(input logic [7:0] b);
    if (char_bytes.size() < 2) char_bytes.push_back(b);
  endtask

  task automatic emit_data(input logic [7:0] b);
    emit(b);
    if (mdl_pending) mdl_high = 4'd0;
  endtask

  task automatic flush_decimal();
    emit_data(mdl_dec_val);
    mdl_dec_val = 8'd0;
    mdl_dec_cnt = 3'd0;
    mdl_mode    = MODE_HEX;
  endtask

  task automatic scan_hex(input logic [7:0] c);
    int nib;
    nib = -1;
    if (c >= "0" && c <= "9") nib = c - "0";
    else if (c >= "a" && c <= "f") nib = c - "a" + 10;
    else if (c >= "A" && c <= "F") nib = c - "A" + 10;
    if (nib >= 0) begin
      if (mdl_pending) begin
        emit({mdl_high, nib[3:0]});
        mdl_pending = 1'b0;
        mdl_high    = 4'd0;
      end else begin
        mdl_high    = nib[3:0];
        mdl_pending = 1'b1;
      end
    end else begin
      case (c)
        CHR_SQUOTE: begin mdl_mode = MODE_LIT; mdl_closer = CHR_SQUOTE; end
        CHR_DQUOTE: begin mdl_mode = MODE_LIT; mdl_closer = CHR_DQUOTE; end
        CHR_LT:     begin mdl_mode = MODE_LIT; mdl_closer = CHR_GT;     end
        CHR_LBRACE: begin mdl_mode = MODE_LIT; mdl_closer = CHR_RBRACE; end
        CHR_LPAREN: begin mdl_mode = MODE_LIT; mdl_closer = CHR_RPAREN; end
        CHR_HASH: begin
          mdl_mode    = MODE_DEC;
          mdl_dec_val = 8'd0;
          mdl_dec_cnt = 3'd0;
        end
        default: ;
      endcase
    end
  endtask

  task automatic decode_char(input logic [7:0] c);
    char_bytes.delete();
    if (c == CHR_NUL) begin
      if (mdl_mode == MODE_DEC) flush_decimal();
      clear_scan();
    end else if (mdl_mode == MODE_LIT) begin
      if (c == mdl_closer) mdl_mode = MODE_HEX;
      else emit_data(c);
    end else if (mdl_mode == MODE_DEC) begin
      if (c >= "0" && c <= "9") begin
        mdl_dec_val = mdl_dec_val * 8'd10 + (c - "0");
        mdl_dec_cnt = mdl_dec_cnt + 3'd1;
        if (mdl_dec_cnt >= MAX_DEC_DIGITS) flush_decimal();
      end else begin
        flush_decimal();
        scan_hex(c);
      end
    end else begin
      scan_hex(c);
    end
    for (int i = 0; i < char_bytes.size(); i++)
      byte_q.push_back('{char_bytes[i], i == char_bytes.size() - 1});
  endtask

  task automatic add_char(input logic [7:0] c);
    text_q.push_back('{c, 1'b0, 1'b0, 8'h00});
  endtask

  task automatic add_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) add_char(8'("0" + v));
    else if ($urandom_range(0, 1) == 1) add_char(8'("A" + v - 10));
    else add_char(8'("a" + v - 10));
  endtask

  task automatic build_random_text();
    int kind;
    int len;
    logic [7:0] opener;
    logic [7:0] closer;
    logic [7:0] c;
    while (text_q.size() < DIR_ROWS + RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        add_hex_digit();
        add_hex_digit();
      end else if (kind < 55) begin
        case ($urandom_range(0, 4))
          0: begin opener = CHR_SQUOTE; closer = CHR_SQUOTE; end
          1: begin opener = CHR_DQUOTE; closer = CHR_DQUOTE; end
          2: begin opener = CHR_LT;     closer = CHR_GT;     end
          3: begin opener = CHR_LBRACE; closer = CHR_RBRACE; end
          default: begin opener = CHR_LPAREN; closer = CHR_RPAREN; end
        endcase
        add_char(opener);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          c = 8'($urandom_range(1, 255));
          if (c == closer) c = c ^ 8'h80;
          add_char(c);
        end
        add_char($urandom_range(0, 99) < 85 ? closer : CHR_NUL);
      end else if (kind < 75) begin
        add_char(CHR_HASH);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) add_char(8'("0" + $urandom_range(0, 9)));
      end else if (kind < 85) begin
        add_char(CHR_NUL);
      end else begin
        add_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_hex_text_to_bytes: errors");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_char   = 8'h00;
    out_ready = 1'b0;
    sent      = 0;
    errors    = 0;
    in_gap    = 0;
    out_gap   = 0;
    clear_scan();
    for (int i = 0; i < DIR_ROWS; i++) text_q.push_back(dir_tbl[i]);
    build_random_text();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (sent < text_q.size()) @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && byte_q.size() == 0) begin
      $display("tb_hex_text_to_bytes: clean");
    end else begin
      $display("tb_hex_text_to_bytes: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (byte_q.size() == 0) begin
          $error("out_byte: expected nothing, actual %h", out_byte);
          errors++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %b, actual %b", want.last, out_last_of_run);
            errors++;
          end
        end
      end

      took = in_valid && in_ready;
      if (took) begin
        row  = text_q[sent];
        base = byte_q.size();
        decode_char(row.chr);
        if (row.typed) begin
          while (byte_q.size() > base) byte_q.delete(byte_q.size() - 1);
          if (row.has_byte) byte_q.push_back('{row.value, 1'b1});
        end
        sent++;
      end

      quiet = (sent + QUIET_TAIL >= text_q.size());

      if (!in_valid || took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
          in_char  <= 8'($urandom_range(0, 255));
        end else if (sent < text_q.size()) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap   = $urandom_range(1, 17) - 1;
            in_valid <= 1'b0;
            in_char  <= 8'($urandom_range(0, 255));
          end else begin
            in_valid <= 1'b1;
            in_char  <= text_q[sent].chr;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap   = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/hxb_pkg.sv
sv/hxb_decode.sv
sv/hxb_out_queue.sv
sv/hex_text_to_bytes.sv
sv/hxb_checker.sv
dv/tb_hex_text_to_bytes.sv
